[src/sgf_pkg.sv]
// Shared types and constants for the Savitzky-Golay row filter.
`default_nettype none
package sgf_pkg;

  localparam int MAX_HALF_WIDTH = 3;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_FRAC_BITS = 16;

  localparam int TAPS         = 2 * MAX_HALF_WIDTH + 1;
  localparam int COEF_BITS    = 19;
  localparam int OUT_BITS     = 20;
  localparam int CFG_HW_BITS  = 2;
  localparam int M_BITS       = $clog2(MAX_HALF_WIDTH + 1);
  localparam int AGE_BITS     = $clog2(TAPS);
  localparam int CNT_BITS     = $clog2(TAPS + 1);
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS     = PROD_BITS + $clog2(TAPS);
  localparam int CFG_IDX_BITS = $clog2(TAPS + 1);
  localparam int CFG_DATA_BITS = COEF_BITS;
  localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_MAX = 2 ** (OUT_BITS - 1) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_BITS - 1));

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_BASE  = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [CFG_HW_BITS-1:0]              half_width;
    logic [TAPS-1:0][COEF_BITS-1:0]      coef;
  } sgf_cfg_t;

  typedef struct packed {
    logic [TAPS-1:0][SAMPLE_BITS-1:0] win;
    logic [AGE_BITS-1:0]              oldest;
    logic [M_BITS-1:0]                m;
    logic [M_BITS-1:0]                first_e;
    logic                             flush;
  } sgf_job_t;

endpackage
`default_nettype wire

[src/sgf_front.sv]
// Front part: window line, row count and job formation for each accepted sample.
`default_nettype none
module sgf_front
  import sgf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sgf_cfg_t               cfg,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   row_end,
  output logic                        push,
  output sgf_job_t                    job,
  input  wire logic                   q_ready
);

  logic [TAPS-1:0][SAMPLE_BITS-1:0] window;
  logic [TAPS-1:0][SAMPLE_BITS-1:0] window_next;
  logic [CNT_BITS-1:0]              row_count;
  logic [CNT_BITS-1:0]              rc_inc;
  logic [AGE_BITS-1:0]              oldest;
  logic [M_BITS-1:0]                m_eff;
  logic                             accept;
  logic                             enough;

  assign in_ready = q_ready;
  assign accept   = in_valid & q_ready;

  assign m_eff = (cfg.half_width > CFG_HW_BITS'(MAX_HALF_WIDTH)) ?
                 M_BITS'(MAX_HALF_WIDTH) : M_BITS'(cfg.half_width);

  assign rc_inc = (row_count < CNT_BITS'(TAPS)) ? row_count + CNT_BITS'(1) : row_count;
  assign oldest = AGE_BITS'(rc_inc - CNT_BITS'(1));
  assign enough = oldest >= AGE_BITS'(m_eff);

  always_comb begin
    window_next[0] = sample;
    for (int i = 1; i < TAPS; i++) begin
      window_next[i] = window[i-1];
    end
  end

  always_comb begin
    job.win     = window_next;
    job.oldest  = oldest;
    job.m       = m_eff;
    job.flush   = row_end;
    job.first_e = (row_end && !enough) ? M_BITS'(oldest) : m_eff;
  end

  assign push = accept & (row_end | enough);

  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      row_count <= '0;
    end else if (accept) begin
      window    <= window_next;
      row_count <= row_end ? '0 : rc_inc;
    end
  end

endmodule
`default_nettype wire

[src/sgf_queue.sv]
// Short job queue between the front and back parts.
`default_nettype none
module sgf_queue
  import sgf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire sgf_job_t push_job,
  output logic          q_ready,
  output logic          q_valid,
  output sgf_job_t      head,
  input  wire logic     pop
);

  sgf_job_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign q_ready = count != QCNT_BITS'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == QCNT_BITS'(QUEUE_DEPTH)))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[src/sgf_back.sv]
// Back part: result sequencing, tap multiply, sum, round, saturate and output register.
`default_nettype none
module sgf_back
  import sgf_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sgf_cfg_t            cfg,
  input  wire logic                q_valid,
  input  wire sgf_job_t            head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [OUT_BITS-1:0] filtered,
  output logic                     row_done
);

  logic                        mid;
  logic [M_BITS-1:0]           e_reg;
  logic [M_BITS-1:0]           cur_e;
  logic                        issue;
  logic                        job_end;
  logic                        res_done;

  logic signed [PROD_BITS-1:0] prod_c [TAPS];
  logic signed [PROD_BITS-1:0] s1_prod [TAPS];
  logic                        s1_valid;
  logic                        s1_done;

  logic signed [ACC_BITS-1:0]  acc_sum;
  logic signed [ACC_BITS-1:0]  s2_acc;
  logic                        s2_valid;
  logic                        s2_done;

  logic signed [ACC_BITS-1:0]  rnd;
  logic signed [ACC_BITS-1:0]  shifted;
  logic signed [OUT_BITS-1:0]  sat;

  logic out_adv;
  logic s2_adv;
  logic s1_adv;

  assign out_adv = !out_valid | out_ready;
  assign s2_adv  = !s2_valid | out_adv;
  assign s1_adv  = !s1_valid | s2_adv;

  assign cur_e    = mid ? e_reg : head.first_e;
  assign issue    = q_valid & s1_adv;
  assign job_end  = !head.flush || cur_e == '0;
  assign res_done = head.flush && cur_e == '0;
  assign pop      = issue & job_end;

  always_comb begin
    int age;
    logic [SAMPLE_BITS-1:0]      sel;
    logic signed [PROD_BITS-1:0] sel_ext;
    logic signed [PROD_BITS-1:0] coef_ext;
    for (int k = 0; k < TAPS; k++) begin
      age = int'(cur_e) + int'(head.m) - k;
      if (age < 0) age = 0;
      if (age > int'(head.oldest)) age = int'(head.oldest);
      sel      = head.win[AGE_BITS'(age)];
      sel_ext  = PROD_BITS'($signed(sel));
      coef_ext = PROD_BITS'($signed(cfg.coef[k]));
      if (k <= 2 * int'(head.m)) begin
        prod_c[k] = sel_ext * coef_ext;
      end else begin
        prod_c[k] = '0;
      end
    end
  end

  always_comb begin
    acc_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      acc_sum = acc_sum + ACC_BITS'(s1_prod[k]);
    end
  end

  assign rnd     = s2_acc + ACC_BITS'(2 ** (COEF_FRAC_BITS - 1));
  assign shifted = rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > ACC_BITS'(OUT_MAX)) begin
      sat = OUT_BITS'(OUT_MAX);
    end else if (shifted < ACC_BITS'(OUT_MIN)) begin
      sat = OUT_BITS'(OUT_MIN);
    end else begin
      sat = shifted[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid   <= 1'b0;
      e_reg <= '0;
    end else if (issue) begin
      if (job_end) begin
        mid <= 1'b0;
      end else begin
        mid   <= 1'b1;
        e_reg <= cur_e - M_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= issue;
      if (s2_adv) s2_valid <= s1_valid;
      if (out_adv) out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_prod <= prod_c;
      s1_done <= res_done;
    end
    if (s2_adv) begin
      s2_acc  <= acc_sum;
      s2_done <= s1_done;
    end
    if (out_adv) begin
      filtered <= sat;
      row_done <= s2_done;
    end
  end

  a_mid_needs_flush: assert property (@(posedge clk) disable iff (rst)
    mid |-> q_valid && head.flush)
    else $error("flush sequence lost its job");

  a_mid_counts_down: assert property (@(posedge clk) disable iff (rst)
    issue && !job_end |=> mid && e_reg == $past(cur_e) - M_BITS'(1))
    else $error("flush sequence did not advance");

endmodule
`default_nettype wire

[src/savitzky_golay_row_filter.sv]
// A job passes the 4-job queue, then the s1 and s2 registers and the output register to m_tvalid.
// One sample per cycle; a row end yields up to half_width+1 results, one per cycle unless m_tready
//   stalls, from the single multiply-and-sum pipeline; s_tready drops only when the queue fills.
// Reset (synchronous, rst high): half_width 2, coefficients 0, window cleared, row count at start
//   of row, queue and pipeline empty.
`default_nettype none
module savitzky_golay_row_filter
  import sgf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [S_TDATA_BITS-1:0]  s_tdata,   // sample
  input  wire logic                     s_tlast,   // row_end
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [M_TDATA_BITS-1:0]       m_tdata,   // filtered, zero fill
  output logic                          m_tlast    // row_done
);

  sgf_cfg_t              cfg;
  logic                  push;
  sgf_job_t              push_job;
  logic                  q_ready;
  logic                  q_valid;
  sgf_job_t              head;
  logic                  pop;
  logic signed [OUT_BITS-1:0] filtered;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_width <= CFG_HW_BITS'(2);
      cfg.coef       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_HALF_WIDTH) begin
        cfg.half_width <= cfg_data[CFG_HW_BITS-1:0];
      end else if (cfg_index <= CFG_IDX_BITS'(TAPS)) begin
        cfg.coef[AGE_BITS'(cfg_index - CFG_COEF_BASE)] <= cfg_data[COEF_BITS-1:0];
      end
    end
  end

  sgf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sample   (s_tdata[SAMPLE_BITS-1:0]),
    .row_end  (s_tlast),
    .push     (push),
    .job      (push_job),
    .q_ready  (q_ready)
  );

  sgf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop)
  );

  sgf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .filtered  (filtered),
    .row_done  (m_tlast)
  );

  assign m_tdata = {{(M_TDATA_BITS - OUT_BITS){1'b0}}, filtered};

endmodule
`default_nettype wire

[sim/savitzky_golay_row_filter_test.sv]
// Self-checking stream testbench for the Savitzky-Golay row filter.
module savitzky_golay_row_filter_test
  import sgf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 10;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_UNITY = COEF_BITS'(1 << COEF_FRAC_BITS);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   row_end;
    logic                   hold_for_drain;
  } row_item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] filtered;
    logic                row_done;
  } filter_result_t;

  typedef enum int {READY_ALWAYS, READY_COIN, READY_PATTERN, READY_SPARSE} ready_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_BITS-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0] m_tdata;
  logic m_tlast;

  savitzky_golay_row_filter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  // filter model state
  logic signed [SAMPLE_BITS-1:0] line_buf [TAPS];
  logic signed [COEF_BITS-1:0]   model_coef [TAPS];
  logic [CFG_HW_BITS-1:0]        model_half_width;
  int                            row_fill;

  row_item_t      pending_samples [$];
  filter_result_t expected_results [$];
  logic signed [COEF_BITS-1:0] coef_plan [TAPS];

  bit in_accepted = 1'b0;
  bit draining = 1'b0;
  bit long_stall_done = 1'b0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int samples_accepted = 0;
  int rows_accepted = 0;
  int drains_done = 0;
  int settings_used = 0;
  int gap_left = 0;
  int burst_left = 0;
  int long_stall_left = 0;
  int mode_left = 0;
  int ready_tick = 0;
  ready_mode_t ready_mode = READY_ALWAYS;

  function automatic logic [OUT_BITS-1:0] window_result(int m, int e);
    longint acc;
    longint r;
    int age;
    int k;
    acc = 0;
    for (k = 0; k <= 2 * m; k++) begin
      age = e + m - k;
      if (age < 0) age = 0;
      if (age > row_fill - 1) age = row_fill - 1;
      if (age > TAPS - 1) age = TAPS - 1;
      acc += longint'(line_buf[age]) * longint'(model_coef[k]);
    end
    r = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (r > longint'(OUT_MAX)) r = longint'(OUT_MAX);
    if (r < longint'(OUT_MIN)) r = longint'(OUT_MIN);
    return r[OUT_BITS-1:0];
  endfunction

  task automatic absorb_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
    int m;
    int first_e;
    int e;
    int i;
    filter_result_t r;
    m = (model_half_width > MAX_HALF_WIDTH) ? MAX_HALF_WIDTH : int'(model_half_width);
    for (i = TAPS - 1; i > 0; i--) line_buf[i] = line_buf[i-1];
    line_buf[0] = $signed(raw);
    if (row_fill < TAPS) row_fill++;
    if (!last) begin
      if (row_fill - 1 >= m) begin
        r.filtered = window_result(m, m);
        r.row_done = 1'b0;
        expected_results.push_back(r);
      end
    end else begin
      first_e = (row_fill - 1 > m) ? m : row_fill - 1;
      for (e = first_e; e >= 0; e--) begin
        r.filtered = window_result(m, e);
        r.row_done = (e == 0);
        expected_results.push_back(r);
      end
      row_fill = 0;
      rows_accepted++;
    end
  endtask

  task automatic flag_output_error(string why, filter_result_t want,
                                   logic [OUT_BITS-1:0] got_val, logic got_last);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch (%s) at output %0d: expected filtered %0d row_done %0b, got %0d / %0b",
               why, results_seen, $signed(want.filtered), want.row_done,
               $signed(got_val), got_last);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // check outputs first, then fold the accepted input into the model
  always @(posedge clk) begin : monitor
    filter_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        want = '0;
        flag_output_error("unexpected", want, m_tdata[OUT_BITS-1:0], m_tlast);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[OUT_BITS-1:0] !== want.filtered || m_tlast !== want.row_done)
          flag_output_error("value", want, m_tdata[OUT_BITS-1:0], m_tlast);
      end
      results_seen++;
    end
    in_accepted = !rst && s_tvalid && s_tready;
    if (in_accepted) begin
      absorb_sample(s_tdata[SAMPLE_BITS-1:0], s_tlast);
      samples_accepted++;
    end
  end

  always @(negedge clk) begin : sender
    row_item_t nxt;
    logic next_valid;
    if (!rst && (!s_tvalid || in_accepted)) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_samples.size() > 0) begin
        if (pending_samples[0].hold_for_drain) begin
          draining = 1'b1;
          if (expected_results.size() == 0) begin
            void'(pending_samples.pop_front());
            draining = 1'b0;
            drains_done++;
          end
        end else begin
          nxt = pending_samples.pop_front();
          s_tdata <= S_TDATA_BITS'(nxt.sample);
          s_tlast <= nxt.row_end;
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      s_tvalid <= next_valid;
    end
  end

  always @(negedge clk) begin : receiver
    logic ready;
    ready = 1'b0;
    if (rst) begin
      ready = 1'b0;
    end else if (long_stall_left > 0) begin
      long_stall_left--;
    end else if (!long_stall_done && results_seen >= 60 && pending_samples.size() > 20
                 && !draining) begin
      long_stall_done = 1'b1;
      long_stall_left = 300;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
        READY_ALWAYS:  ready = 1'b1;
        READY_COIN:    ready = 1'($urandom_range(0, 1));
        READY_PATTERN: ready = (ready_tick % 4) != 3;
        READY_SPARSE:  ready = ($urandom_range(0, 7) == 0);
        default:       ready = 1'b1;
      endcase
    end
    m_tready <= ready;
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_HALF_WIDTH)
      model_half_width = value[CFG_HW_BITS-1:0];
    else
      model_coef[int'(idx - CFG_COEF_BASE)] = value;
  endtask

  task automatic set_config(int hw);
    int k;
    write_reg(CFG_HALF_WIDTH, CFG_DATA_BITS'(hw));
    for (k = 0; k < TAPS; k++)
      write_reg(CFG_COEF_BASE + CFG_IDX_BITS'(k), coef_plan[k]);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic plan_coefs(logic signed [COEF_BITS-1:0] c0, logic signed [COEF_BITS-1:0] c1,
                            logic signed [COEF_BITS-1:0] c2, logic signed [COEF_BITS-1:0] c3,
                            logic signed [COEF_BITS-1:0] c4, logic signed [COEF_BITS-1:0] c5,
                            logic signed [COEF_BITS-1:0] c6);
    coef_plan[0] = c0; coef_plan[1] = c1; coef_plan[2] = c2; coef_plan[3] = c3;
    coef_plan[4] = c4; coef_plan[5] = c5; coef_plan[6] = c6;
  endtask

  task automatic plan_random_coefs();
    int k;
    for (k = 0; k < TAPS; k++) coef_plan[k] = COEF_BITS'($urandom);
  endtask

  task automatic push_sample(logic [SAMPLE_BITS-1:0] s, logic last);
    row_item_t it;
    it.sample = s;
    it.row_end = last;
    it.hold_for_drain = 1'b0;
    pending_samples.push_back(it);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_BITS'($urandom_range(0, 16) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_rows(int n);
    int count;
    int len;
    int i;
    row_item_t it;
    count = 0;
    while (count < n) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      for (i = 0; i < len; i++) push_sample(pick_sample(), i == len - 1);
      count += len;
      if ($urandom_range(0, 7) == 0) begin
        it = '0;
        it.hold_for_drain = 1'b1;
        pending_samples.push_back(it);
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int k;
    int i;
    model_half_width = CFG_HW_BITS'(2);
    row_fill = 0;
    for (k = 0; k < TAPS; k++) begin
      line_buf[k] = '0;
      model_coef[k] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full window, most negative weights: saturate both ways
    plan_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    set_config(3);
    for (i = 0; i < 7; i++) push_sample(SAMPLE_MIN, i == 6);
    for (i = 0; i < 7; i++) push_sample(SAMPLE_MAX, i == 6);
    wait_idle();

    // quadratic smoother, unused taps at max; single-sample and short rows
    plan_coefs(-19'sd5617, 19'sd22469, 19'sd31832, 19'sd22469, -19'sd5617, COEF_MAX, COEF_MAX);
    set_config(2);
    push_sample(SAMPLE_BITS'(12345), 1'b1);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b1);
    push_sample('0, 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b0);
    push_sample(SAMPLE_BITS'(-1), 1'b0);
    wait_idle();

    // shrink the window in the middle of a row
    plan_coefs(COEF_UNITY, '0, '0, '0, '0, '0, '0);
    set_config(0);
    push_sample(SAMPLE_BITS'(100), 1'b0);
    push_sample(SAMPLE_BITS'(-100), 1'b1);
    wait_idle();

    plan_random_coefs();
    set_config(1);
    queue_rows(90);
    wait_idle();

    plan_random_coefs();
    set_config(3);
    queue_rows(90);
    wait_idle();

    plan_coefs(-19'sd5617, 19'sd22469, 19'sd31832, 19'sd22469, -19'sd5617,
               COEF_BITS'($urandom), COEF_BITS'($urandom));
    set_config(2);
    queue_rows(90);
    wait_idle();

    plan_random_coefs();
    set_config(0);
    queue_rows(90);
    wait_idle();

    plan_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    set_config(3);
    queue_rows(90);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d samples in %0d rows, %0d filtered outputs, %0d register settings",
             samples_accepted, rows_accepted, results_seen, settings_used);
    $display("%0d drain pauses, long output stall %s, %0d mismatches, %0d outputs missing",
             drains_done, long_stall_done ? "done" : "not reached", mismatch_count,
             expected_results.size());
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
